// File: src/cbaw_pkg.sv
// package: shared types and constants for the clamped block average window
`timescale 1ns / 1ps
package cbaw_pkg;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int ENTRY_W     = 64;
    localparam int PT_W        = 65;

    localparam logic [1:0] REG_LOWER  = 2'd0;
    localparam logic [1:0] REG_UPPER  = 2'd1;
    localparam logic [1:0] REG_GROUP  = 2'd2;
    localparam logic [1:0] REG_WINDOW = 2'd3;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // command passed from front to back
    typedef struct packed {
        logic [31:0]       now_ms;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  newest;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_DIV,
        ST_LOAD,
        ST_EMIT,
        ST_EMPTY
    } walk_state_t;
endpackage

// File: src/cbaw_ram.sv
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
module cbaw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/cbaw_front.sv
// front part: clamps and stores samples, hands queries to the back part
`timescale 1ns / 1ps
module cbaw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy_back,
    input  logic                        operation,
    input  logic signed [15:0]          sample_x,
    input  logic signed [15:0]          sample_y,
    input  logic [31:0]                 sample_time_ms,
    input  logic [31:0]                 now_ms,
    input  logic signed [15:0]          lower_threshold,
    input  logic signed [15:0]          upper_threshold,
    output logic                        busy,
    output logic                        we,
    output logic [cbaw_pkg::IDX_W-1:0]  waddr,
    output logic [cbaw_pkg::ENTRY_W-1:0] wdata,
    output logic                        cmd_valid,
    output cbaw_pkg::cmd_t              cmd
);
    logic [cbaw_pkg::IDX_W-1:0] widx_reg;
    logic [cbaw_pkg::CNT_W-1:0] count_reg;
    logic                       qv_reg;
    cbaw_pkg::cmd_t             q_reg;
    logic                       accept;
    logic signed [15:0]         cx, cy;

    function automatic logic signed [15:0] clamp(
        input logic signed [15:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [15:0] r;
        r = v;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r;
    endfunction

    assign busy   = qv_reg | busy_back;
    assign accept = start & ~busy;
    assign cx     = clamp(sample_x, lower_threshold, upper_threshold);
    assign cy     = clamp(sample_y, lower_threshold, upper_threshold);
    assign we     = accept & (operation == cbaw_pkg::OP_ADD);
    assign waddr  = widx_reg;
    assign wdata  = {cx, cy, sample_time_ms};

    // ring pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg  <= '0;
            count_reg <= '0;
        end
        else if (we)
        begin
            widx_reg <= widx_reg + 1'b1;
            if (count_reg != cbaw_pkg::CNT_W'(cbaw_pkg::STORE_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // one deep command queue toward the back part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
        end
        else if (accept && operation == cbaw_pkg::OP_QUERY)
        begin
            qv_reg <= 1'b1;
        end
        else if (qv_reg && !busy_back)
        begin
            qv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == cbaw_pkg::OP_QUERY)
        begin
            q_reg.now_ms   <= now_ms;
            q_reg.count    <= count_reg;
            q_reg.newest   <= widx_reg - 1'b1;
        end
    end

    assign cmd_valid = qv_reg & ~busy_back;
    assign cmd       = q_reg;
endmodule

// File: src/cbaw_back.sv
// back part: walks the ring, sums groups, divides and emits points
`timescale 1ns / 1ps
module cbaw_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  cbaw_pkg::cmd_t               cmd,
    input  logic [6:0]                   group_size,
    input  logic [31:0]                  plot_window_ms,
    input  logic [cbaw_pkg::ENTRY_W-1:0] rdata,
    output logic [cbaw_pkg::IDX_W-1:0]   raddr,
    output logic                         busy_back,
    output logic                         result_valid,
    output logic signed [15:0]           avg_x,
    output logic signed [15:0]           avg_y,
    output logic signed [32:0]           time_offset_ms,
    output logic                         point_valid,
    output logic                         last_point
);
    cbaw_pkg::walk_state_t state_reg, state_next;
    logic [cbaw_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [cbaw_pkg::CNT_W-1:0] left_reg, left_next;
    logic [6:0]  cnt_reg, cnt_next, gs_reg, gs_next;
    logic [31:0] now_reg, now_next;
    logic signed [22:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [32:0] anchor_reg, anchor_next;
    // division: magnitude restoring, one quotient bit per cycle
    logic [22:0] rx_reg, rx_next, ry_reg, ry_next, qx_reg, qx_next, qy_reg, qy_next;
    logic        nx_reg, nx_next, ny_reg, ny_next;
    logic [4:0]  dstep_reg, dstep_next;
    // point stack written newest first, read oldest first
    logic [cbaw_pkg::IDX_W-1:0] pt_waddr, pt_raddr;
    logic [cbaw_pkg::PT_W-1:0]  pt_wdata, pt_rdata;
    logic [6:0]  ng_reg, ng_next;
    logic        push;
    logic signed [15:0] push_x, push_y;
    logic signed [32:0] age;
    logic signed [22:0] ex, ey;
    logic [23:0] tx, ty;

    assign raddr = pos_reg;
    assign busy_back = (state_reg != cbaw_pkg::ST_IDLE);
    assign age = $signed({1'b0, now_reg}) - $signed({1'b0, rdata[31:0]});
    assign ex  = 23'($signed(rdata[63:48]));
    assign ey  = 23'($signed(rdata[47:32]));
    assign tx  = {1'b0, rx_reg[21:0], qx_reg[22]} - {17'd0, gs_reg};
    assign ty  = {1'b0, ry_reg[21:0], qy_reg[22]} - {17'd0, gs_reg};
    assign push_x = nx_reg ? -16'(qx_next) : 16'(qx_next);
    assign push_y = ny_reg ? -16'(qy_next) : 16'(qy_next);

    // point stack: fetch address is taken from the next count, so the registered read holds the point emitted next
    assign pt_waddr = 6'(ng_reg);
    assign pt_wdata = {push_x, push_y, -anchor_reg};
    assign pt_raddr = 6'(ng_next - 1'b1);

    cbaw_ram #(.WIDTH(cbaw_pkg::PT_W), .DEPTH(cbaw_pkg::STORE_DEPTH)) u_points (
        .clk, .we(push), .waddr(pt_waddr), .wdata(pt_wdata), .raddr(pt_raddr),
        .rdata(pt_rdata)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbaw_pkg::ST_IDLE;
            ng_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ng_reg    <= ng_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next; left_reg <= left_next; cnt_reg <= cnt_next;
        gs_reg <= gs_next; now_reg <= now_next; sx_reg <= sx_next; sy_reg <= sy_next;
        anchor_reg <= anchor_next; rx_reg <= rx_next; ry_reg <= ry_next;
        qx_reg <= qx_next; qy_reg <= qy_next; nx_reg <= nx_next; ny_reg <= ny_next;
        dstep_reg <= dstep_next;
    end

    // walk sequencer
    always_comb
    begin
        state_next = state_reg; pos_next = pos_reg; left_next = left_reg;
        cnt_next = cnt_reg; gs_next = gs_reg; now_next = now_reg;
        sx_next = sx_reg; sy_next = sy_reg; anchor_next = anchor_reg;
        rx_next = rx_reg; ry_next = ry_reg; qx_next = qx_reg; qy_next = qy_reg;
        nx_next = nx_reg; ny_next = ny_reg; dstep_next = dstep_reg;
        ng_next = ng_reg; push = 1'b0;
        result_valid = 1'b0; avg_x = '0; avg_y = '0; time_offset_ms = '0;
        point_valid = 1'b0; last_point = 1'b0;
        case (state_reg)
            cbaw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    now_next  = cmd.now_ms;
                    left_next = cmd.count;
                    pos_next  = cmd.newest;
                    cnt_next  = '0; sx_next = '0; sy_next = '0; ng_next = '0;
                    gs_next   = (group_size == 7'd0) ? 7'd1 :
                                (group_size > 7'd64) ? 7'd64 : group_size;
                    state_next = (cmd.count == '0) ? cbaw_pkg::ST_EMPTY : cbaw_pkg::ST_READ;
                end
            end
            cbaw_pkg::ST_READ:
            begin
                state_next = cbaw_pkg::ST_WALK;
            end
            cbaw_pkg::ST_WALK:
            begin
                if (age > $signed({1'b0, plot_window_ms}))
                begin
                    state_next = (ng_reg == '0) ? cbaw_pkg::ST_EMPTY : cbaw_pkg::ST_EMIT;
                end
                else
                begin
                    if (cnt_reg == '0) anchor_next = age;
                    sx_next = sx_reg + ex;
                    sy_next = sy_reg + ey;
                    pos_next = pos_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                    if (cnt_reg + 1'b1 == gs_reg)
                    begin
                        cnt_next = '0;
                        nx_next = sx_next[22]; ny_next = sy_next[22];
                        qx_next = sx_next[22] ? -sx_next : sx_next;
                        qy_next = sy_next[22] ? -sy_next : sy_next;
                        rx_next = '0; ry_next = '0; dstep_next = '0;
                        state_next = cbaw_pkg::ST_DIV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = (left_reg == 7'd1) ?
                            ((ng_reg == '0) ? cbaw_pkg::ST_EMPTY : cbaw_pkg::ST_EMIT) :
                            cbaw_pkg::ST_READ;
                    end
                end
            end
            cbaw_pkg::ST_DIV:
            begin
                qx_next = {qx_reg[21:0], ~tx[23]};
                rx_next = tx[23] ? {rx_reg[21:0], qx_reg[22]} : tx[22:0];
                qy_next = {qy_reg[21:0], ~ty[23]};
                ry_next = ty[23] ? {ry_reg[21:0], qy_reg[22]} : ty[22:0];
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == 5'd22)
                begin
                    push = 1'b1;
                    ng_next = ng_reg + 1'b1;
                    sx_next = '0; sy_next = '0;
                    state_next = (left_reg == '0 || ng_next == 7'd64) ?
                        cbaw_pkg::ST_LOAD : cbaw_pkg::ST_READ;
                end
            end
            // oldest point was just written, fetch it
            cbaw_pkg::ST_LOAD:
            begin
                state_next = cbaw_pkg::ST_EMIT;
            end
            cbaw_pkg::ST_EMIT:
            begin
                result_valid = 1'b1; point_valid = 1'b1;
                avg_x = pt_rdata[64:49]; avg_y = pt_rdata[48:33];
                time_offset_ms = pt_rdata[32:0];
                last_point = (ng_reg == 7'd1);
                ng_next = ng_reg - 1'b1;
                if (ng_reg == 7'd1) state_next = cbaw_pkg::ST_IDLE;
            end
            cbaw_pkg::ST_EMPTY:
            begin
                result_valid = 1'b1; last_point = 1'b1;
                state_next = cbaw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cbaw_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// File: src/clip_and_block_average_window.sv
// top level: clamped block average over a ring of timestamped samples
`timescale 1ns / 1ps
// An add word stores a clamped sample in a 64-entry ring. A query word waits
// in the command register, then walks back from the newest sample, reading
// each sample from the registered ring and then accumulating it, with a
// bit-serial division per complete group and a fetch of the oldest point when
// the walk ends on a division, then sends one point per cycle, oldest first.
// busy is high while a query waits or runs. Points appear on strobe for one
// cycle each and cannot be held off.
module clip_and_block_average_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [15:0] sample_x,
    input  logic signed [15:0] sample_y,
    input  logic [31:0]        sample_time_ms,
    input  logic [31:0]        now_ms,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               strobe,
    output logic signed [15:0] avg_x,
    output logic signed [15:0] avg_y,
    output logic signed [32:0] time_offset_ms,
    output logic               point_valid,
    output logic               last_point
);
    logic signed [15:0] lower_reg, upper_reg;
    logic [6:0]  group_reg;
    logic [31:0] window_reg;
    logic        busy_back, we, cmd_valid;
    logic [cbaw_pkg::IDX_W-1:0]   waddr, raddr;
    logic [cbaw_pkg::ENTRY_W-1:0] wdata, rdata;
    cbaw_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= 16'sd0;
            upper_reg  <= 16'sd25600;
            group_reg  <= 7'd5;
            window_reg <= 32'd10000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cbaw_pkg::REG_LOWER:  lower_reg  <= cfg_data[15:0];
                cbaw_pkg::REG_UPPER:  upper_reg  <= cfg_data[15:0];
                cbaw_pkg::REG_GROUP:  group_reg  <= cfg_data[6:0];
                cbaw_pkg::REG_WINDOW: window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cbaw_front u_front (
        .clk, .rst_n, .start, .busy_back, .operation, .sample_x, .sample_y,
        .sample_time_ms, .now_ms, .lower_threshold(lower_reg),
        .upper_threshold(upper_reg), .busy, .we, .waddr, .wdata, .cmd_valid, .cmd
    );

    cbaw_ram #(.WIDTH(cbaw_pkg::ENTRY_W), .DEPTH(cbaw_pkg::STORE_DEPTH)) u_ram (
        .clk, .we, .waddr, .wdata, .raddr, .rdata
    );

    cbaw_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd, .group_size(group_reg),
        .plot_window_ms(window_reg), .rdata, .raddr, .busy_back,
        .result_valid(strobe), .avg_x, .avg_y, .time_offset_ms, .point_valid,
        .last_point
    );

    // no point while idle, an empty answer is last, and no point after the last
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("point strobe outside a query");
    a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !point_valid) |-> last_point) else $error("empty answer not last");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_point) |=> !strobe) else $error("point after last");
endmodule
